FILE: src/cpbe_pkg.sv
// shared types, widths and codes for the clamped point box extent block
package cpbe_pkg;

    // coordinate width, signed fixed point Q8.16 at the default
    localparam int COORD_W   = 24;
    localparam int LIMIT_W   = 23;
    localparam int OUT_W     = 24;
    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 2;

    // room for centre plus or minus limit
    localparam int EXT_W  = ((COORD_W > LIMIT_W) ? COORD_W : LIMIT_W) + 2;
    // sign extended centre before taking the low output bits
    localparam int SX_W   = (COORD_W > OUT_W) ? COORD_W : OUT_W;
    // max minus min of two coordinates
    localparam int DIFF_W = COORD_W + 1;
    // size before saturation, always wider than the output
    localparam int SZ_W   = (DIFF_W > OUT_W) ? DIFF_W : OUT_W + 1;

    localparam logic [OUT_W-1:0] SIZE_MAX = '1;

    localparam logic [LIMIT_W-1:0] LIMIT_X_RST = LIMIT_W'(32768);
    localparam logic [LIMIT_W-1:0] LIMIT_Y_RST = LIMIT_W'(65536);
    localparam logic [LIMIT_W-1:0] LIMIT_Z_RST = LIMIT_W'(32768);

    localparam logic FUNC_CENTRE = 1'b0;
    localparam logic FUNC_POINT  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_X = 2'd0,
        REG_LIMIT_Y = 2'd1,
        REG_LIMIT_Z = 2'd2
    } t_reg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [LIMIT_W-1:0]        t_limit;

    typedef struct packed {
        logic   func;
        t_coord px;
        t_coord py;
        t_coord pz;
        logic   point_valid;
        logic   last;
    } t_pt_item;

    typedef struct packed {
        logic        [OUT_W-1:0] size_x;
        logic        [OUT_W-1:0] size_y;
        logic        [OUT_W-1:0] size_z;
        logic signed [OUT_W-1:0] centre_x;
        logic signed [OUT_W-1:0] centre_y;
        logic signed [OUT_W-1:0] centre_z;
        logic                    empty_box;
    } t_res_item;

    // per axis control from the box sequencing logic
    typedef struct packed {
        logic start;   // centre item, load centre and clear extent
        logic update;  // valid point in an open box
        logic seen;    // a valid point was already taken in this box
    } t_axis_ctl;

endpackage

FILE: src/cpbe_pt_if.sv
// point item channel
interface cpbe_pt_if;
    logic               valid;
    logic               ready;
    cpbe_pkg::t_pt_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cpbe_res_if.sv
// result item channel
interface cpbe_res_if;
    logic                valid;
    logic                ready;
    cpbe_pkg::t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cpbe_cfg.sv
// limit register file written through the configuration port
module cpbe_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cpbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cpbe_pkg::LIMIT_W-1:0]      i_cfg_data,
    output cpbe_pkg::t_limit                  o_limit_x,
    output cpbe_pkg::t_limit                  o_limit_y,
    output cpbe_pkg::t_limit                  o_limit_z
);
    cpbe_pkg::t_limit r_limit_x, r_limit_y, r_limit_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_x <= cpbe_pkg::LIMIT_X_RST;
            r_limit_y <= cpbe_pkg::LIMIT_Y_RST;
            r_limit_z <= cpbe_pkg::LIMIT_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpbe_pkg::REG_LIMIT_X: r_limit_x <= i_cfg_data;
                cpbe_pkg::REG_LIMIT_Y: r_limit_y <= i_cfg_data;
                cpbe_pkg::REG_LIMIT_Z: r_limit_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_limit_x = r_limit_x;
    assign o_limit_y = r_limit_y;
    assign o_limit_z = r_limit_z;
endmodule

FILE: src/cpbe_axis.sv
// one axis: clamp to centre window, running min and max, extent
module cpbe_axis (
    input  logic                              i_clk,
    input  cpbe_pkg::t_axis_ctl               i_ctl,
    input  cpbe_pkg::t_coord                  i_p,
    input  cpbe_pkg::t_limit                  i_limit,
    output logic [cpbe_pkg::OUT_W-1:0]        o_size,
    output logic signed [cpbe_pkg::OUT_W-1:0] o_centre
);
    cpbe_pkg::t_coord r_centre, r_min, r_max;
    cpbe_pkg::t_coord n_centre, n_min, n_max;
    cpbe_pkg::t_coord q;

    logic signed [cpbe_pkg::EXT_W-1:0]  p_e, c_e, l_e, hi, lo, q_e;
    logic signed [cpbe_pkg::DIFF_W-1:0] diff;
    logic        [cpbe_pkg::SZ_W-1:0]   sz_wide;
    logic signed [cpbe_pkg::SX_W-1:0]   c_sx;

    // clamp window around the stored centre
    always_comb begin
        p_e = cpbe_pkg::EXT_W'(i_p);
        c_e = cpbe_pkg::EXT_W'(r_centre);
        l_e = $signed({{(cpbe_pkg::EXT_W-cpbe_pkg::LIMIT_W){1'b0}}, i_limit});
        hi  = c_e + l_e;
        lo  = c_e - l_e;
        if (p_e > hi) begin
            q_e = hi;
        end else if (p_e < lo) begin
            q_e = lo;
        end else begin
            q_e = p_e;
        end
        // clamped value always lies between the point and the centre
        q = $signed(q_e[cpbe_pkg::COORD_W-1:0]);
    end

    always_comb begin
        n_centre = r_centre;
        n_min    = r_min;
        n_max    = r_max;
        if (i_ctl.start) begin
            n_centre = i_p;
            n_min    = '0;
            n_max    = '0;
        end else if (i_ctl.update) begin
            if (!i_ctl.seen || q < r_min) begin
                n_min = q;
            end
            if (!i_ctl.seen || q > r_max) begin
                n_max = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_centre <= n_centre;
        r_min    <= n_min;
        r_max    <= n_max;
    end

    // extent from the updated bounds, saturated to the output width
    always_comb begin
        diff    = cpbe_pkg::DIFF_W'(n_max) - cpbe_pkg::DIFF_W'(n_min);
        sz_wide = cpbe_pkg::SZ_W'($unsigned(diff));
        if (sz_wide > cpbe_pkg::SZ_W'(cpbe_pkg::SIZE_MAX)) begin
            o_size = cpbe_pkg::SIZE_MAX;
        end else begin
            o_size = sz_wide[cpbe_pkg::OUT_W-1:0];
        end
        c_sx     = cpbe_pkg::SX_W'(n_centre);
        o_centre = $signed(c_sx[cpbe_pkg::OUT_W-1:0]);
    end
endmodule

FILE: src/clamped_point_box_extent_core.sv
// top level of the clamped point box extent block
//
//  channel  | dir | payload       | handshake
//  ---------+-----+---------------+-----------------------------------
//  i_pt     | in  | t_pt_item     | valid/ready, taken when both high
//  o_res    | out | t_res_item    | valid/ready, taken when both high
//  i_cfg_*  | in  | limit x, y, z | write enable, index, data
//
// one item per cycle sustained unless a stalled result register holds one back;
// an item is held in the input register, then its min/max update and result
// go out through the result register
// synchronous active low reset clears both valid flags, the open box flags
// and the limits to their defaults
// a stalled result register holds the input register only for items that
// give a result; other items keep flowing past it
module clamped_point_box_extent_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cpbe_pt_if.sink                        i_pt,
    cpbe_res_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [cpbe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpbe_pkg::LIMIT_W-1:0]   i_cfg_data
);
    cpbe_pkg::t_limit limit_x, limit_y, limit_z;

    // input register
    logic               r_s1_v;
    cpbe_pkg::t_pt_item r_s1;

    // box sequencing state
    logic r_active, r_seen;
    logic n_active, n_seen;

    // result register
    logic                r_o_v;
    cpbe_pkg::t_res_item r_o;

    cpbe_pkg::t_axis_ctl ctl;
    logic                has_res;
    logic                s1_go;
    logic                seen_now;
    logic                active_now;

    logic        [cpbe_pkg::OUT_W-1:0] size_x, size_y, size_z;
    logic signed [cpbe_pkg::OUT_W-1:0] cen_x, cen_y, cen_z;

    cpbe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_limit_x  (limit_x),
        .o_limit_y  (limit_y),
        .o_limit_z  (limit_z)
    );

    // box sequencing for the item in the input register
    always_comb begin
        ctl.start  = s1_go && (r_s1.func == cpbe_pkg::FUNC_CENTRE);
        ctl.update = s1_go && (r_s1.func == cpbe_pkg::FUNC_POINT) && r_active
                     && r_s1.point_valid;
        ctl.seen   = r_seen;

        // state after this item's point, before the last flag closes the box
        if (r_s1.func == cpbe_pkg::FUNC_CENTRE) begin
            active_now = r_s1.point_valid;
            seen_now   = 1'b0;
        end else begin
            active_now = r_active;
            seen_now   = r_seen || (r_active && r_s1.point_valid);
        end

        // only an open box closed by a last item gives a result
        has_res = r_s1.last && active_now;
        s1_go   = r_s1_v && (!has_res || !r_o_v || o_res.ready);

        n_active = r_active;
        n_seen   = r_seen;
        if (s1_go) begin
            n_active = active_now && !r_s1.last;
            n_seen   = seen_now && !r_s1.last;
        end
    end

    assign i_pt.ready = !r_s1_v || s1_go;

    cpbe_axis u_axis_x (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_p      (r_s1.px),
        .i_limit  (limit_x),
        .o_size   (size_x),
        .o_centre (cen_x)
    );

    cpbe_axis u_axis_y (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_p      (r_s1.py),
        .i_limit  (limit_y),
        .o_size   (size_y),
        .o_centre (cen_y)
    );

    cpbe_axis u_axis_z (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_p      (r_s1.pz),
        .i_limit  (limit_z),
        .o_size   (size_z),
        .o_centre (cen_z)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_pt.ready) begin
            r_s1_v <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.ready && i_pt.valid) begin
            r_s1 <= i_pt.data;
        end
    end

    // open box flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_seen   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_seen   <= n_seen;
        end
    end

    // result register, sizes forced to zero for an empty box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_go && has_res) begin
            r_o_v <= 1'b1;
        end else if (o_res.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && has_res) begin
            r_o.size_x    <= seen_now ? size_x : '0;
            r_o.size_y    <= seen_now ? size_y : '0;
            r_o.size_z    <= seen_now ? size_z : '0;
            r_o.centre_x  <= cen_x;
            r_o.centre_y  <= cen_y;
            r_o.centre_z  <= cen_z;
            r_o.empty_box <= !seen_now;
        end
    end

    assign o_res.valid = r_o_v;
    assign o_res.data  = r_o;
endmodule
